### src/sqks_pkg.sv
// Shared types and constants of the shift queue with key search.
`default_nettype none

package sqks_pkg;

   // Default number of entries the queue can hold.
   localparam int CAPACITY_DEF = 16;

   // Operation codes carried by the mode field of a request beat.
   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   // Controller states, one-hot.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_PICK = 2'b10
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic load_rsp;
   } cmd_type;

endpackage

`default_nettype wire

### src/shift_queue_with_key_search.sv
// Top level of the bounded shift queue with search by id and read by position.
`default_nettype none

// A bounded queue of CAPACITY records, each a signed 32-bit id and a 64-bit name,
// kept packed from the head. Each request beat is an insert at the tail, a removal of
// the head, a search for the first id equal to the key, or a read at a 1-based
// position, and it yields exactly one response beat with the status, the entry found
// (zero when none), and the count and empty and full flags after the operation. For
// each item, at the accepting edge every cell compares in parallel and the cells
// shift or take the new entry; in the next cycle the match nearest the head is
// picked into the output register. The next request is accepted in the cycle after
// that pick, so a new item cannot start before the last one has been picked; a
// response left waiting holds the pick cycle until the register frees.
// The cells need no clearing after reset.
module shift_queue_with_key_search #(
   parameter int CAPACITY = sqks_pkg::CAPACITY_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic        [1:0]  req_mode,
   input  wire logic signed [31:0] req_item_id,
   input  wire logic        [63:0] req_item_name,
   input  wire logic        [4:0]  req_position,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_status,
   output logic signed      [31:0] rsp_found_id,
   output logic             [63:0] rsp_found_name,
   output logic             [4:0]  rsp_entry_count,
   output logic                    rsp_is_empty,
   output logic                    rsp_is_full
);

   sqks_pkg::cmd_type cmd;

   // Sequencing of request, pick and response beats.
   sqks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Entry cells and result path.
   sqks_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_mode),
      .req_item_id     (req_item_id),
      .req_item_name   (req_item_name),
      .req_position    (req_position),
      .rsp_status      (rsp_status),
      .rsp_found_id    (rsp_found_id),
      .rsp_found_name  (rsp_found_name),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

endmodule

`default_nettype wire

### src/sqks_ctrl.sv
// Controller that sequences request acceptance, the pick cycle and the result register.
`default_nettype none

module sqks_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sqks_pkg::cmd_type     cmd
);

   sqks_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic take_req;
   logic load_out;

   // A request is taken only while no operation is waiting to be picked.
   assign req_ready = (state_ff == sqks_pkg::ST_IDLE);
   assign take_req  = req_valid && req_ready;

   // The result register can be loaded once its previous beat is gone or leaving.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_out = (state_ff == sqks_pkg::ST_PICK) && out_free;

   // Command bundle to the datapath.
   always_comb begin
      cmd.accept   = take_req;
      cmd.load_rsp = load_out;
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sqks_pkg::ST_IDLE: begin
            if (take_req) begin
               state_in = sqks_pkg::ST_PICK;
            end
         end
         sqks_pkg::ST_PICK: begin
            if (out_free) begin
               state_in = sqks_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sqks_pkg::ST_IDLE;
         end
      endcase
   end

   // The result beat stays valid until the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sqks_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### src/sqks_datapath.sv
// Datapath: the shifting entry cells, per-cell match logic, first-match pick and result register.
`default_nettype none

module sqks_datapath #(
   parameter int CAPACITY = sqks_pkg::CAPACITY_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sqks_pkg::cmd_type  cmd,
   input  wire logic        [1:0]  req_mode,
   input  wire logic signed [31:0] req_item_id,
   input  wire logic        [63:0] req_item_name,
   input  wire logic        [4:0]  req_position,
   output logic                    rsp_status,
   output logic signed      [31:0] rsp_found_id,
   output logic             [63:0] rsp_found_name,
   output logic             [4:0]  rsp_entry_count,
   output logic                    rsp_is_empty,
   output logic                    rsp_is_full
);

   localparam int CW = $clog2(CAPACITY + 1);

   sqks_pkg::mode_type mode;

   // Entry cells, packed from the head at cell zero.
   logic signed [31:0] id_ff   [CAPACITY];
   logic        [63:0] name_ff [CAPACITY];

   logic [CW-1:0]       count_ff, count_in;
   logic [CAPACITY-1:0] hit_ff, hit_in;
   logic [CAPACITY-1:0] first_hit;
   logic                lookup_ff, lookup_in;
   logic                fail_ff, fail_in;
   logic                q_full, q_empty;

   logic signed [31:0]  pick_id;
   logic        [63:0]  pick_name;

   logic                status_ff;
   logic signed [31:0]  found_id_ff;
   logic        [63:0]  found_name_ff;
   logic        [4:0]   entry_count_ff;
   logic                is_empty_ff, is_full_ff;

   assign mode    = sqks_pkg::mode_type'(req_mode);
   assign q_full  = (count_ff == CW'(CAPACITY));
   assign q_empty = (count_ff == '0);

   // Per-cell key match (search) or position match (read); count and fail for insert/remove.
   always_comb begin
      hit_in    = '0;
      lookup_in = 1'b0;
      fail_in   = 1'b0;
      count_in  = count_ff;
      unique case (mode)
         sqks_pkg::MODE_INSERT: begin
            fail_in = q_full;
            if (!q_full) begin
               count_in = count_ff + CW'(1);
            end
         end
         sqks_pkg::MODE_REMOVE: begin
            fail_in = q_empty;
            if (!q_empty) begin
               count_in = count_ff - CW'(1);
            end
         end
         sqks_pkg::MODE_SEARCH: begin
            lookup_in = 1'b1;
            for (int i = 0; i < CAPACITY; i++) begin
               hit_in[i] = (32'(i) < 32'(count_ff)) && (id_ff[i] == req_item_id);
            end
         end
         sqks_pkg::MODE_READ: begin
            lookup_in = 1'b1;
            for (int i = 0; i < CAPACITY; i++) begin
               hit_in[i] = (32'(i) < 32'(count_ff)) &&
                           (32'(req_position) == 32'(i) + 32'd1);
            end
         end
         default: begin
            lookup_in = 1'b0;
         end
      endcase
   end

   // Count, match vector and operation flags are captured with the request beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.accept) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hit_ff    <= hit_in;
         lookup_ff <= lookup_in;
         fail_ff   <= fail_in;
      end
   end

   // Insert writes the tail cell; remove shifts every cell but the last one place toward the head.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if ((mode == sqks_pkg::MODE_INSERT) && !q_full) begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (CW'(i) == count_ff) begin
                  id_ff[i]   <= req_item_id;
                  name_ff[i] <= req_item_name;
               end
            end
         end else if ((mode == sqks_pkg::MODE_REMOVE) && !q_empty) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
               id_ff[i]   <= id_ff[i + 1];
               name_ff[i] <= name_ff[i + 1];
            end
         end
      end
   end

   // Keep only the match nearest the head, then gather that entry.
   assign first_hit = hit_ff & (~hit_ff + CAPACITY'(1));

   always_comb begin
      pick_id   = '0;
      pick_name = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         pick_id   = pick_id   | (first_hit[i] ? id_ff[i]   : 32'sd0);
         pick_name = pick_name | (first_hit[i] ? name_ff[i] : 64'd0);
      end
   end

   // Result register, loaded in the pick cycle.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff      <= lookup_ff ? (hit_ff == '0) : fail_ff;
         found_id_ff    <= pick_id;
         found_name_ff  <= pick_name;
         entry_count_ff <= 5'(count_ff);
         is_empty_ff    <= q_empty;
         is_full_ff     <= q_full;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_found_id    = found_id_ff;
   assign rsp_found_name  = found_name_ff;
   assign rsp_entry_count = entry_count_ff;
   assign rsp_is_empty    = is_empty_ff;
   assign rsp_is_full     = is_full_ff;

`ifndef SYNTHESIS
   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("entry count exceeds capacity");

   // An accepted insert into a queue with room grows the count by one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && (mode == sqks_pkg::MODE_INSERT) && !q_full) |=>
      (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not advance the count");

   // The pick selects at most one cell.
   a_pick_onehot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> $onehot0(first_hit))
      else $error("first-match pick selected more than one cell");
`endif

endmodule

`default_nettype wire
